>>> hdl/tcm_pkg.sv
// Shared types and constants of the touch calibrate and map unit.
// No dependencies; every other file of the block imports this package.
package tcm_pkg;

    localparam int RAW_W      = 10;     // raw converter reading
    localparam int SCR_W      = 11;     // screen coordinate and size
    localparam int STATUS_W   = 3;
    localparam int PT_IDX_W   = 3;      // calibration point index
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_PTS    = 5;

    localparam int SAMPLE_LIMIT = 128;
    localparam int CNT_W        = 8;    // holds SAMPLE_LIMIT
    localparam int SUM_W        = 17;   // SAMPLE_LIMIT * (2**RAW_W - 1)
    localparam int MARGIN       = 50;

    localparam int GAIN_FRAC  = 16;
    localparam int GAIN_W     = 25;
    localparam int GAIN_MAX   = 2 ** (GAIN_W - 1) - 1;
    localparam int SD_W       = 12;     // signed spans and point differences

    // Divider: magnitude of 2*span << GAIN_FRAC over a 12 bit divisor.
    localparam int DIV_DW     = SCR_W + GAIN_FRAC + 1;
    localparam int DIV_DVW    = SD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_DW);

    // Mapping accumulator: gain * raw difference plus half size in Q.16.
    localparam int ACC_W      = GAIN_W + RAW_W + 2;
    localparam int M_W        = ACC_W - GAIN_FRAC;

    localparam logic [SCR_W-1:0] RESET_WIDTH  = SCR_W'(480);
    localparam logic [SCR_W-1:0] RESET_HEIGHT = SCR_W'(272);

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [STATUS_W-1:0] ST_COLLECT  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CAPTURED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CAL_DONE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MAPPED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OUT_RNG  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CAL_FAIL = 3'd5;

    localparam logic [PT_IDX_W-1:0] PT_A = 3'd0;
    localparam logic [PT_IDX_W-1:0] PT_B = 3'd1;
    localparam logic [PT_IDX_W-1:0] PT_C = 3'd2;
    localparam logic [PT_IDX_W-1:0] PT_D = 3'd3;
    localparam logic [PT_IDX_W-1:0] PT_E = 3'd4;

    typedef struct packed {
        logic                start;
        logic [DIV_DW-1:0]   dividend;
        logic [DIV_DVW-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_DW-1:0]   quotient;
    } t_div_rsp;

endpackage

>>> hdl/tcm_if.sv
// Valid/ready channel interfaces of the touch calibrate and map unit.
// Depends on tcm_pkg for the field widths.
interface tcm_in_if;
    import tcm_pkg::*;
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic             pressed;
    modport source (output valid, opcode, raw_x, raw_y, pressed, input ready);
    modport sink   (input valid, opcode, raw_x, raw_y, pressed, output ready);
endinterface

interface tcm_out_if;
    import tcm_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SCR_W-1:0]    screen_x;
    logic [SCR_W-1:0]    screen_y;
    logic                pen_down;
    logic [PT_IDX_W-1:0] point_index;
    logic [SCR_W-1:0]    target_x;
    logic [SCR_W-1:0]    target_y;
    modport source (output valid, status, screen_x, screen_y, pen_down, point_index,
                    target_x, target_y, input ready);
    modport sink   (input valid, status, screen_x, screen_y, pen_down, point_index,
                    target_x, target_y, output ready);
endinterface

interface tcm_cfg_if;
    import tcm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SCR_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/touch_calibrate_and_map_unit.sv
// Touch calibrate and map unit: five-point calibration and linear mapping.
// Depends on tcm_pkg, the channel interfaces in tcm_if.sv and tcm_div.
//
//  Port    | Dir | Beat contents
//  --------+-----+---------------------------------------------------------
//  i_in    | in  | opcode, raw_x, raw_y, pressed
//  o_out   | out | status, screen_x, screen_y, pen_down, point_index, targets
//  i_cfg   | in  | index (0 width, 1 height), data; always ready
//
// One beat is taken at a time. A mapped beat makes two passes through the
// shared multiplier stages. Capturing a point on release takes two runs of
// the divider; after point E two more runs form the gains. Reset is
// synchronous and active low. A result waiting at o_out does not block the
// next input beat, only the hand-over of the following result.
module touch_calibrate_and_map_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcm_in_if.sink    i_in,
    tcm_out_if.source o_out,
    tcm_cfg_if.sink   i_cfg
);
    import tcm_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DIVX  = 10'b00_0000_0010,
        S_DIVY  = 10'b00_0000_0100,
        S_SETUP = 10'b00_0000_1000,
        S_GAINX = 10'b00_0001_0000,
        S_GAINY = 10'b00_0010_0000,
        S_MUL   = 10'b00_0100_0000,
        S_ADD   = 10'b00_1000_0000,
        S_RND   = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration and calibration state.
    logic [SCR_W-1:0]         r_width, r_height;
    logic                     r_calibrated;
    logic [PT_IDX_W-1:0]      r_pc;
    logic                     r_seen;
    logic [SUM_W-1:0]         r_sum_x, r_sum_y;
    logic [CNT_W-1:0]         r_cnt;
    logic [RAW_W-1:0]         r_px [NUM_PTS];
    logic [RAW_W-1:0]         r_py [NUM_PTS];
    logic [RAW_W-1:0]         r_avg_x;
    logic                     r_swapped;
    logic signed [GAIN_W-1:0] r_gain_x, r_gain_y;
    logic [RAW_W-1:0]         r_cx, r_cy;
    logic                     r_sw, r_s_neg, r_d_neg;
    logic [SD_W-1:0]          r_d_mag;

    // Mapping work registers.
    logic [RAW_W-1:0]         r_ux, r_uy;
    logic                     r_pen;
    logic                     r_axis;
    logic signed [ACC_W-1:0]  r_acc;
    logic [SCR_W-1:0]         r_mx;
    logic                     r_oor;

    // Result staging and output register.
    logic [STATUS_W-1:0]      r_status;
    logic [SCR_W-1:0]         r_sx, r_sy;
    logic                     r_pd;
    logic                     r_o_valid;
    logic [STATUS_W-1:0]      r_o_status;
    logic [SCR_W-1:0]         r_o_sx, r_o_sy;
    logic                     r_o_pd;
    logic [PT_IDX_W-1:0]      r_o_pidx;
    logic [SCR_W-1:0]         r_o_tx, r_o_ty;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic                     w_in_fire, w_out_free;
    logic                     w_restart, w_release_ok;
    logic [PT_IDX_W-1:0]      w_pc;
    logic [SUM_W-1:0]         w_base_x, w_base_y;
    logic [CNT_W-1:0]         w_base_cnt;
    logic [RAW_W-1:0]         w_q_avg;

    logic signed [RAW_W:0]    w_dx, w_dy;
    logic [RAW_W:0]           w_adx, w_ady;
    logic                     w_sw;
    logic [RAW_W-1:0]         w_qx [NUM_PTS];
    logic [RAW_W-1:0]         w_qy [NUM_PTS];
    logic [SD_W-1:0]          w_s, w_d, w_s_mag, w_d_mag;
    logic                     w_div_zero;
    logic [SD_W-1:0]          w_span_x, w_span_y;
    logic [SCR_W-1:0]         w_span_x_mag, w_span_y_mag;
    logic [DIV_DW-1:0]        w_num_x, w_num_y;

    logic [RAW_W-1:0]         w_sel_u, w_sel_c;
    logic signed [GAIN_W-1:0] w_sel_g;
    logic [SCR_W-1:0]         w_sel_size;
    logic signed [RAW_W:0]    w_diff;
    logic signed [GAIN_W+RAW_W:0] w_prod;
    logic signed [ACC_W-1:0]  w_offset, w_bias, w_round;
    logic [M_W-1:0]           w_m;
    logic                     w_m_oor;

    logic [SCR_W-1:0]         w_tx, w_ty;

    function automatic logic signed [GAIN_W-1:0] f_sat(input logic neg,
                                                       input logic [DIV_DW-1:0] q);
        logic signed [GAIN_W-1:0] res;
        if (!neg) begin
            res = (q > DIV_DW'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : q[GAIN_W-1:0];
        end else begin
            res = (q > DIV_DW'(GAIN_MAX + 1)) ? {1'b1, {(GAIN_W-1){1'b0}}}
                                              : GAIN_W'(0) - q[GAIN_W-1:0];
        end
        return res;
    endfunction

    tcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // ---------------------------------------------------------------- handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_fire   = i_in.valid & i_in.ready;
    assign w_out_free  = ~r_o_valid | o_out.ready;

    assign o_out.valid       = r_o_valid;
    assign o_out.status      = r_o_status;
    assign o_out.screen_x    = r_o_sx;
    assign o_out.screen_y    = r_o_sy;
    assign o_out.pen_down    = r_o_pd;
    assign o_out.point_index = r_o_pidx;
    assign o_out.target_x    = r_o_tx;
    assign o_out.target_y    = r_o_ty;

    // ------------------------------------------------------------ capture logic
    assign w_restart    = (i_in.opcode == OP_RESTART);
    assign w_release_ok = r_seen & (r_cnt != '0);
    assign w_pc         = (r_pc > PT_E) ? PT_E : r_pc;
    assign w_base_x     = r_seen ? r_sum_x : '0;
    assign w_base_y     = r_seen ? r_sum_y : '0;
    assign w_base_cnt   = r_seen ? r_cnt : '0;
    assign w_q_avg      = w_rsp.quotient[RAW_W-1:0];

    // ----------------------------------------------------- calibration solve
    assign w_dx  = $signed({1'b0, r_px[PT_B]}) - $signed({1'b0, r_px[PT_A]});
    assign w_dy  = $signed({1'b0, r_py[PT_B]}) - $signed({1'b0, r_py[PT_A]});
    assign w_adx = w_dx[RAW_W] ? (RAW_W+1)'(-w_dx) : w_dx;
    assign w_ady = w_dy[RAW_W] ? (RAW_W+1)'(-w_dy) : w_dy;
    // A tie in the A to B spreads counts as swapped axes.
    assign w_sw  = ~(w_adx > w_ady);

    always_comb begin
        for (int i = 0; i < NUM_PTS; i++) begin
            w_qx[i] = w_sw ? r_py[i] : r_px[i];
            w_qy[i] = w_sw ? r_px[i] : r_py[i];
        end
    end

    assign w_s = SD_W'(w_qx[PT_B]) - SD_W'(w_qx[PT_A]) + SD_W'(w_qx[PT_C]) - SD_W'(w_qx[PT_D]);
    assign w_d = SD_W'(w_qy[PT_D]) - SD_W'(w_qy[PT_A]) + SD_W'(w_qy[PT_C]) - SD_W'(w_qy[PT_B]);
    assign w_s_mag    = w_s[SD_W-1] ? SD_W'(0) - w_s : w_s;
    assign w_d_mag    = w_d[SD_W-1] ? SD_W'(0) - w_d : w_d;
    assign w_div_zero = (w_s == '0) | (w_d == '0);

    assign w_span_x     = SD_W'(r_width) - SD_W'(2 * MARGIN);
    assign w_span_y     = SD_W'(r_height) - SD_W'(2 * MARGIN);
    assign w_span_x_mag = w_span_x[SD_W-1] ? SCR_W'(SD_W'(0) - w_span_x) : SCR_W'(w_span_x);
    assign w_span_y_mag = w_span_y[SD_W-1] ? SCR_W'(SD_W'(0) - w_span_y) : SCR_W'(w_span_y);
    assign w_num_x      = DIV_DW'(w_span_x_mag) << (GAIN_FRAC + 1);
    assign w_num_y      = DIV_DW'(w_span_y_mag) << (GAIN_FRAC + 1);

    // ------------------------------------------------------------ mapping path
    assign w_sel_u    = r_axis ? r_uy : r_ux;
    assign w_sel_c    = r_axis ? r_cy : r_cx;
    assign w_sel_g    = r_axis ? r_gain_y : r_gain_x;
    assign w_sel_size = r_axis ? r_height : r_width;
    assign w_diff     = $signed({1'b0, w_sel_u}) - $signed({1'b0, w_sel_c});
    assign w_prod     = w_sel_g * w_diff;
    assign w_offset   = ACC_W'({w_sel_size[SCR_W-1:1], {GAIN_FRAC{1'b0}}});
    // Adding 2^F - 1 to a negative sum makes the shift round toward zero.
    assign w_bias     = r_acc[ACC_W-1] ? ACC_W'(2 ** GAIN_FRAC - 1) : '0;
    assign w_round    = r_acc + w_bias;
    assign w_m        = w_round[ACC_W-1:GAIN_FRAC];
    assign w_m_oor    = w_m[M_W-1] | (w_m[M_W-2:0] >= (M_W-1)'(w_sel_size));

    // ------------------------------------------------------------ target point
    always_comb begin
        case (w_pc)
            PT_A: begin
                w_tx = SCR_W'(MARGIN);
                w_ty = SCR_W'(MARGIN);
            end
            PT_B: begin
                w_tx = r_width - SCR_W'(MARGIN);
                w_ty = SCR_W'(MARGIN);
            end
            PT_C: begin
                w_tx = r_width - SCR_W'(MARGIN);
                w_ty = r_height - SCR_W'(MARGIN);
            end
            PT_D: begin
                w_tx = SCR_W'(MARGIN);
                w_ty = r_height - SCR_W'(MARGIN);
            end
            default: begin
                w_tx = r_width >> 1;
                w_ty = r_height >> 1;
            end
        endcase
    end

    // ------------------------------------------------------ sequencer control
    always_comb begin
        n_state = r_state;
        w_req   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (w_restart) begin
                        n_state = S_EMIT;
                    end else if (r_calibrated) begin
                        n_state = S_MUL;
                    end else if (!i_in.pressed && w_release_ok) begin
                        n_state        = S_DIVX;
                        w_req.start    = 1'b1;
                        w_req.dividend = DIV_DW'(r_sum_x);
                        w_req.divisor  = DIV_DVW'(r_cnt);
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_DIVX: begin
                if (w_rsp.done) begin
                    n_state        = S_DIVY;
                    w_req.start    = 1'b1;
                    w_req.dividend = DIV_DW'(r_sum_y);
                    w_req.divisor  = DIV_DVW'(r_cnt);
                end
            end
            S_DIVY: begin
                if (w_rsp.done) begin
                    n_state = (w_pc < PT_E) ? S_EMIT : S_SETUP;
                end
            end
            S_SETUP: begin
                if (w_div_zero) begin
                    n_state = S_EMIT;
                end else begin
                    n_state        = S_GAINX;
                    w_req.start    = 1'b1;
                    w_req.dividend = w_num_x;
                    w_req.divisor  = w_s_mag;
                end
            end
            S_GAINX: begin
                if (w_rsp.done) begin
                    n_state        = S_GAINY;
                    w_req.start    = 1'b1;
                    w_req.dividend = w_num_y;
                    w_req.divisor  = r_d_mag;
                end
            end
            S_GAINY: begin
                if (w_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_MUL:  n_state = S_ADD;
            S_ADD:  n_state = S_RND;
            S_RND:  n_state = r_axis ? S_EMIT : S_MUL;
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ----------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_width      <= RESET_WIDTH;
            r_height     <= RESET_HEIGHT;
            r_calibrated <= 1'b0;
            r_pc         <= PT_A;
            r_seen       <= 1'b0;
            r_sum_x      <= '0;
            r_sum_y      <= '0;
            r_cnt        <= '0;
            r_swapped    <= 1'b0;
            r_gain_x     <= '0;
            r_gain_y     <= '0;
            r_cx         <= '0;
            r_cy         <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_SCREEN_WIDTH:  r_width  <= i_cfg.data;
                    REG_SCREEN_HEIGHT: r_height <= i_cfg.data;
                    default: ;
                endcase
            end

            if (r_state == S_EMIT && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        if (w_restart) begin
                            r_calibrated <= 1'b0;
                            r_pc         <= PT_A;
                            r_seen       <= 1'b0;
                            r_sum_x      <= '0;
                            r_sum_y      <= '0;
                            r_cnt        <= '0;
                        end else if (!r_calibrated && i_in.pressed) begin
                            // Samples past the cap still count as a press.
                            r_seen <= 1'b1;
                            if (w_base_cnt < CNT_W'(SAMPLE_LIMIT)) begin
                                r_sum_x <= w_base_x + SUM_W'(i_in.raw_x);
                                r_sum_y <= w_base_y + SUM_W'(i_in.raw_y);
                                r_cnt   <= w_base_cnt + 1'b1;
                            end else begin
                                r_sum_x <= w_base_x;
                                r_sum_y <= w_base_y;
                                r_cnt   <= w_base_cnt;
                            end
                        end
                    end
                end
                S_DIVY: begin
                    if (w_rsp.done) begin
                        r_seen  <= 1'b0;
                        r_sum_x <= '0;
                        r_sum_y <= '0;
                        r_cnt   <= '0;
                        if (w_pc < PT_E) begin
                            r_pc <= w_pc + 1'b1;
                        end
                    end
                end
                S_SETUP: begin
                    if (w_div_zero) begin
                        r_pc <= PT_A;
                    end
                end
                S_GAINX: begin
                    if (w_rsp.done) begin
                        r_gain_x <= f_sat(w_span_x[SD_W-1] ^ r_s_neg, w_rsp.quotient);
                    end
                end
                S_GAINY: begin
                    if (w_rsp.done) begin
                        r_gain_y     <= f_sat(w_span_y[SD_W-1] ^ r_d_neg, w_rsp.quotient);
                        r_swapped    <= r_sw;
                        r_cx         <= r_sw ? r_py[PT_E] : r_px[PT_E];
                        r_cy         <= r_sw ? r_px[PT_E] : r_py[PT_E];
                        r_calibrated <= 1'b1;
                        r_pc         <= PT_A;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ data path
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    r_status <= ST_COLLECT;
                    r_sx     <= '0;
                    r_sy     <= '0;
                    r_pd     <= 1'b0;
                    r_ux     <= r_swapped ? i_in.raw_y : i_in.raw_x;
                    r_uy     <= r_swapped ? i_in.raw_x : i_in.raw_y;
                    r_pen    <= i_in.pressed;
                    r_axis   <= 1'b0;
                end
            end
            S_DIVX: begin
                if (w_rsp.done) begin
                    r_avg_x <= w_q_avg;
                end
            end
            S_DIVY: begin
                if (w_rsp.done) begin
                    r_px[w_pc] <= r_avg_x;
                    r_py[w_pc] <= w_q_avg;
                    r_status   <= ST_CAPTURED;
                end
            end
            S_SETUP: begin
                r_sw     <= w_sw;
                r_s_neg  <= w_s[SD_W-1];
                r_d_neg  <= w_d[SD_W-1];
                r_d_mag  <= w_d_mag;
                r_status <= ST_CAL_FAIL;
            end
            S_GAINY: begin
                r_status <= ST_CAL_DONE;
            end
            S_MUL: begin
                r_acc <= ACC_W'(w_prod);
            end
            S_ADD: begin
                r_acc <= r_acc + w_offset;
            end
            S_RND: begin
                if (!r_axis) begin
                    r_mx   <= w_m[SCR_W-1:0];
                    r_oor  <= w_m_oor;
                    r_axis <= 1'b1;
                end else if (r_oor || w_m_oor) begin
                    r_status <= ST_OUT_RNG;
                end else begin
                    r_status <= ST_MAPPED;
                    r_sx     <= r_mx;
                    r_sy     <= w_m[SCR_W-1:0];
                    r_pd     <= r_pen;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_o_status <= r_status;
                    r_o_sx     <= r_sx;
                    r_o_sy     <= r_sy;
                    r_o_pd     <= r_pd;
                    r_o_pidx   <= r_calibrated ? PT_A : w_pc;
                    r_o_tx     <= r_calibrated ? '0 : w_tx;
                    r_o_ty     <= r_calibrated ? '0 : w_ty;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> hdl/tcm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tcm_pkg for the request and response structs.
module tcm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcm_pkg::t_div_req i_req,
    output tcm_pkg::t_div_rsp o_rsp
);
    import tcm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DW-1:0]    r_quo;
    logic [DIV_DVW-1:0]   r_rem;
    logic [DIV_DVW-1:0]   r_dvs;
    logic [DIV_DVW:0]     w_shift;
    logic [DIV_DVW:0]     w_diff;

    // The dividend shifts out at the top of r_quo while quotient bits enter below.
    assign w_shift = {r_rem, r_quo[DIV_DW-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_DW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_diff[DIV_DVW] ? w_shift[DIV_DVW-1:0] : w_diff[DIV_DVW-1:0];
            r_quo <= {r_quo[DIV_DW-2:0], ~w_diff[DIV_DVW]};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
